@@ rtl/core/smvhd_pkg.sv @@
package smvhd_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int MAG_W         = 16;
    localparam int ACC_W         = 28;
    localparam int THRESH_W      = 16;
    localparam int HOLD_W        = 20;
    localparam int CFG_W         = 20;
    localparam int CFG_IDX_W     = 1;
    localparam int KIND_W        = 2;
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 24;

    localparam int MAX_FRAME_SAMPLES = 2048;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd100;
    localparam logic [HOLD_W-1:0]   HOLD_RESET   = 20'd30000;
    localparam logic [ACC_W-1:0]    ACC_MAX      = {ACC_W{1'b1}};
    localparam logic [HOLD_W-1:0]   SIL_MAX      = {HOLD_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_WAKE   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 1'b0,
        REG_HOLD      = 1'b1
    } cfg_reg_t;

    // One item as seen by the detector state.
    typedef struct packed {
        logic             en;
        kind_t            kind;
        logic [MAG_W-1:0] mag;
        logic             fend;
        logic             busy;
    } det_step_t;

    // Frame decisions for the item in flight.
    typedef struct packed {
        logic voice;
        logic req;
    } det_result_t;

endpackage

@@ rtl/core/smvhd_mix.sv @@
module smvhd_mix
(
    input  logic signed [smvhd_pkg::SAMPLE_W-1:0] left_sample,
    input  logic signed [smvhd_pkg::SAMPLE_W-1:0] right_sample,
    output logic signed [smvhd_pkg::SAMPLE_W-1:0] mono_sample,
    output logic        [smvhd_pkg::MAG_W-1:0]    mono_mag
);

    logic signed [smvhd_pkg::SAMPLE_W:0] pair_sum;

    // floor((L+R)/2) always fits 16 bits, so no clamp is needed
    assign pair_sum    = {left_sample[smvhd_pkg::SAMPLE_W-1], left_sample}
                       + {right_sample[smvhd_pkg::SAMPLE_W-1], right_sample};
    assign mono_sample = pair_sum[smvhd_pkg::SAMPLE_W:1];

    // -(-32768) wraps to 0x8000, which is the right unsigned magnitude
    assign mono_mag = mono_sample[smvhd_pkg::SAMPLE_W-1]
                    ? smvhd_pkg::MAG_W'(-mono_sample)
                    : smvhd_pkg::MAG_W'(mono_sample);

endmodule

@@ rtl/core/smvhd_det.sv @@
module smvhd_det
#(
    parameter int MAX_FRAME_SAMPLES = smvhd_pkg::MAX_FRAME_SAMPLES
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [smvhd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [smvhd_pkg::CFG_W-1:0]       cfg_data,
    input  smvhd_pkg::det_step_t              step,
    output smvhd_pkg::det_result_t            result
);

    localparam int CNT_W  = (MAX_FRAME_SAMPLES > 1) ? $clog2(MAX_FRAME_SAMPLES) : 1;
    localparam int PROD_W = smvhd_pkg::THRESH_W + CNT_W + 1;
    localparam int CMP_W  = (PROD_W > smvhd_pkg::ACC_W) ? PROD_W : smvhd_pkg::ACC_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_SAMPLES - 1);

    logic [smvhd_pkg::THRESH_W-1:0] thresh_reg;
    logic [smvhd_pkg::HOLD_W-1:0]   hold_reg;
    logic [smvhd_pkg::ACC_W-1:0]    acc_reg,    acc_next;
    logic [CNT_W-1:0]               cnt_reg,    cnt_next;
    logic [smvhd_pkg::HOLD_W-1:0]   sil_reg,    sil_next;
    logic                           asleep_reg, asleep_next;
    logic                           wake_reg,   wake_next;

    logic [smvhd_pkg::ACC_W:0]      acc_sum;
    logic [smvhd_pkg::ACC_W-1:0]    acc_sat;
    logic [CNT_W:0]                 frame_len;
    logic [PROD_W-1:0]              thresh_prod;
    logic                           voice;
    logic [smvhd_pkg::HOLD_W-1:0]   sil_at_end;
    logic                           req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= smvhd_pkg::THRESH_RESET;
            hold_reg   <= smvhd_pkg::HOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (smvhd_pkg::cfg_reg_t'(cfg_index))
                smvhd_pkg::REG_THRESHOLD: thresh_reg <= cfg_data[smvhd_pkg::THRESH_W-1:0];
                smvhd_pkg::REG_HOLD:      hold_reg   <= cfg_data[smvhd_pkg::HOLD_W-1:0];
                default:                  ;
            endcase
        end
    end

    assign acc_sum     = {1'b0, acc_reg} + (smvhd_pkg::ACC_W+1)'(step.mag);
    assign acc_sat     = acc_sum[smvhd_pkg::ACC_W] ? smvhd_pkg::ACC_MAX
                                                   : acc_sum[smvhd_pkg::ACC_W-1:0];
    assign frame_len   = {1'b0, cnt_reg} + (CNT_W+1)'(1);
    assign thresh_prod = PROD_W'(thresh_reg) * PROD_W'(frame_len);
    assign voice       = CMP_W'(acc_sat) >= CMP_W'(thresh_prod);
    assign sil_at_end  = (wake_reg || voice) ? '0 : sil_reg;
    assign req         = !asleep_reg && !step.busy && (sil_at_end >= hold_reg);

    always_comb
    begin
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        sil_next    = sil_reg;
        asleep_next = asleep_reg;
        wake_next   = wake_reg;
        if (step.en)
        begin
            case (step.kind)
                smvhd_pkg::KIND_SAMPLE:
                begin
                    if (step.fend)
                    begin
                        acc_next    = '0;
                        cnt_next    = '0;
                        wake_next   = 1'b0;
                        sil_next    = sil_at_end;
                        asleep_next = asleep_reg || req;
                    end
                    else
                    begin
                        acc_next = acc_sat;
                        if (cnt_reg < CNT_MAX)
                            cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                smvhd_pkg::KIND_TICK:
                begin
                    if (sil_reg != smvhd_pkg::SIL_MAX)
                        sil_next = sil_reg + smvhd_pkg::HOLD_W'(1);
                end
                smvhd_pkg::KIND_WAKE:
                begin
                    asleep_next = 1'b0;
                    wake_next   = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            cnt_reg    <= '0;
            sil_reg    <= '0;
            asleep_reg <= 1'b0;
            wake_reg   <= 1'b0;
        end
        else
        begin
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            sil_reg    <= sil_next;
            asleep_reg <= asleep_next;
            wake_reg   <= wake_next;
        end
    end

    assign result.voice = step.fend && voice;
    assign result.req   = step.fend && req;

`ifndef NO_ASSERTIONS
    // sleep is entered only through a request at a frame end
    a_asleep_by_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(asleep_reg) |-> $past(step.en && step.fend && req
                                    && step.kind == smvhd_pkg::KIND_SAMPLE))
        else $error("asleep set without a sleep request");
`endif

endmodule

@@ rtl/core/stereo_mix_voice_hold_detector_core.sv @@
// Channel   Dir  Bus                     Contents (low bit up)
// s_*       in   tdata[39:0]             left_sample, right_sample, transfer_busy
//                tuser[1:0]              kind (sample / tick / wake)
//                tlast                   frame_end
// m_*       out  tdata[23:0]             mono_sample, voice_seen, sleep_request
//                tlast                   frame_done
// cfg_*     in   we / index / data[19:0] 0 voice_threshold, 1 silence_hold_ms
//
// One item per clock unless a sample item is stalled by m_tready. An item is
// held in the input register, then the mixer and detector logic updates state
// and loads the result register, which drives m_tvalid. Ticks and wakes give
// no result. An item leaves the input register whenever it makes no result
// or the result register is empty or being drained, so m_tready only stalls
// sample items. Reset (rst_n, async) sets the valid flags, detector state
// and config registers to defaults.
module stereo_mix_voice_hold_detector_core
#(
    parameter int MAX_FRAME_SAMPLES = smvhd_pkg::MAX_FRAME_SAMPLES
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // left_sample[15:0], right_sample[31:16], transfer_busy[32], zero pad
    input  logic [smvhd_pkg::IN_TDATA_W-1:0]      s_tdata,
    // kind[1:0]
    input  logic [smvhd_pkg::KIND_W-1:0]          s_tuser,
    input  logic                                  s_tlast,

    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // mono_sample[15:0], voice_seen[16], sleep_request[17], zero pad
    output logic [smvhd_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                  m_tlast,

    input  logic                                  cfg_we,
    input  logic [smvhd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [smvhd_pkg::CFG_W-1:0]           cfg_data
);

    localparam int SW = smvhd_pkg::SAMPLE_W;

    // input register
    logic                  in_v_reg;
    smvhd_pkg::kind_t      in_kind_reg;
    logic signed [SW-1:0]  in_left_reg;
    logic signed [SW-1:0]  in_right_reg;
    logic                  in_fend_reg;
    logic                  in_busy_reg;

    // result register
    logic                  out_v_reg;
    logic signed [SW-1:0]  out_mono_reg;
    logic                  out_last_reg;
    logic                  out_voice_reg;
    logic                  out_req_reg;

    logic                   is_sample;
    logic                   advance;
    logic signed [SW-1:0]   mono;
    logic [smvhd_pkg::MAG_W-1:0] mag;
    smvhd_pkg::det_step_t   step;
    smvhd_pkg::det_result_t dres;

    assign is_sample = (in_kind_reg == smvhd_pkg::KIND_SAMPLE);
    assign advance   = in_v_reg && (!is_sample || !out_v_reg || m_tready);
    assign s_tready  = !in_v_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (s_tready)
            in_v_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_kind_reg  <= smvhd_pkg::kind_t'(s_tuser);
            in_left_reg  <= s_tdata[SW-1:0];
            in_right_reg <= s_tdata[2*SW-1:SW];
            in_busy_reg  <= s_tdata[2*SW];
            in_fend_reg  <= s_tlast;
        end
    end

    smvhd_mix u_mix
    (
        .left_sample  (in_left_reg),
        .right_sample (in_right_reg),
        .mono_sample  (mono),
        .mono_mag     (mag)
    );

    assign step.en   = advance;
    assign step.kind = in_kind_reg;
    assign step.mag  = mag;
    assign step.fend = in_fend_reg;
    assign step.busy = in_busy_reg;

    smvhd_det #(
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
    ) u_det
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .result    (dres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (advance && is_sample)
            out_v_reg <= 1'b1;
        else if (m_tready)
            out_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_sample)
        begin
            out_mono_reg  <= mono;
            out_last_reg  <= in_fend_reg;
            out_voice_reg <= dres.voice;
            out_req_reg   <= dres.req;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(smvhd_pkg::OUT_TDATA_W - SW - 2){1'b0}},
                       out_req_reg, out_voice_reg, out_mono_reg};

`ifndef NO_ASSERTIONS
    // the input side only stalls while an item is held
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_v_reg)
        else $error("input stalled with empty input register");

    // ticks and wakes load no result; the result register can only drain
    a_no_result_for_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !is_sample) |=> (out_v_reg == $past(out_v_reg && !m_tready)))
        else $error("control item produced a result");

    // decisions are only reported on the item that closes a frame
    a_decision_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_last_reg) |-> (!out_voice_reg && !out_req_reg))
        else $error("decision flagged outside a frame end");

    // a held result is not overwritten
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !m_tready) |=> (out_v_reg && $stable(out_mono_reg)))
        else $error("stalled result changed");
`endif

endmodule
